// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by bmd_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/bmd_pkg.sv -----
package bmd_pkg;

	// default widths
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF  = 20;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_SAMPLES = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_BINS   = 2'd1;

	// controller to datapath commands
	typedef struct packed {
		logic load_sample;
		logic size_start;
		logic size_load;
		logic accum;
		logic mean_start;
		logic emit_bin;
		logic emit_pass;
	} bmd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic compress;
		logic fill_zero;
		logic bin_end;
		logic size_busy;
		logic mean_busy;
		logic out_free;
	} bmd_status_t;

endpackage

// ----- rtl/core/bmd_divider.sv -----
module bmd_divider
	import bmd_pkg::*;
#(
	parameter int DW = COUNT_BITS_DEF + 1,
	parameter int QW = COUNT_BITS_DEF,
	parameter int VW = COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [QW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CW = $clog2(QW + 1);

	logic [VW-1:0] rem_q;
	logic [QW-1:0] qd_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;

	logic [VW:0]   shifted;
	logic [VW:0]   diff;
	logic          fits;
	logic [VW-1:0] rem_next;

	// one restoring step: bring down the next dividend bit
	assign shifted  = {rem_q, qd_q[QW-1]};
	assign diff     = shifted - {1'b0, dvs_q};
	assign fits     = (shifted >= {1'b0, dvs_q});
	assign rem_next = fits ? diff[VW-1:0] : shifted[VW-1:0];

	assign busy      = (cnt_q != '0);
	assign quotient  = qd_q;
	assign remainder = rem_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// partial remainder and dividend / quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= VW'(dividend[DW-1:QW]);
			qd_q  <= dividend[QW-1:0];
			dvs_q <= divisor;
		end else if (busy) begin
			rem_q <= rem_next;
			qd_q  <= {qd_q[QW-2:0], fits};
		end
	end

endmodule

// ----- rtl/core/bmd_datapath.sv -----
`include "assert_macros.svh"

module bmd_datapath
	import bmd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [COUNT_BITS-1:0]         cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] x_sample,
	input  logic signed [SAMPLE_BITS-1:0] y_sample,
	input  bmd_cmd_t                      cmd,
	output bmd_status_t                   status,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] mean_x,
	output logic signed [SAMPLE_BITS-1:0] mean_y,
	output logic [COUNT_BITS-1:0]         bin_count,
	output logic                          last_point
);

	localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
	localparam int ERR_BITS = COUNT_BITS + 1;

	// configuration
	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] target_q;

	// run state
	logic [COUNT_BITS-1:0]      index_q;
	logic [ERR_BITS-1:0]        err_q;
	logic [COUNT_BITS-1:0]      size_q;
	logic [COUNT_BITS-1:0]      fill_q;
	logic signed [SUM_BITS-1:0] sum_x_q;
	logic signed [SUM_BITS-1:0] sum_y_q;
	logic                       last_q;

	// sample holding registers
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mean_x_q;
	logic signed [SAMPLE_BITS-1:0] mean_y_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic                          last_point_q;

	logic                  run_clear;
	logic [COUNT_BITS-1:0] index_inc;
	logic [COUNT_BITS-1:0] fill_inc;
	logic                  is_last;
	logic [ERR_BITS-1:0]   err_sum;

	logic [COUNT_BITS-1:0] size_quot;
	logic [COUNT_BITS-1:0] size_rem;
	logic                  size_busy;

	logic [SUM_BITS-1:0]    abs_x;
	logic [SUM_BITS-1:0]    abs_y;
	logic [SAMPLE_BITS-1:0] quot_x;
	logic [SAMPLE_BITS-1:0] quot_y;
	logic [COUNT_BITS-1:0]  rem_x;
	logic [COUNT_BITS-1:0]  rem_y;
	logic                   busy_x;
	logic                   busy_y;
	logic [SAMPLE_BITS-1:0] mean_x_val;
	logic [SAMPLE_BITS-1:0] mean_y_val;

	// a write to either configuration register starts a new run
	assign run_clear = cfg_we && (cfg_index inside {REG_TOTAL_SAMPLES, REG_TARGET_BINS});

	// position and bin bookkeeping
	assign index_inc = index_q + 1'b1;
	assign fill_inc  = fill_q + 1'b1;
	assign is_last   = (total_q != '0) && (index_inc == total_q);
	assign err_sum   = err_q + ERR_BITS'(total_q);

	// status to controller
	assign status.compress  = (target_q != '0) && (target_q < total_q);
	assign status.fill_zero = (fill_q == '0);
	assign status.bin_end   = (fill_inc != '0) && ((fill_inc >= size_q) || is_last);
	assign status.size_busy = size_busy;
	assign status.mean_busy = busy_x | busy_y;
	assign status.out_free  = !out_valid_q || !out_stall;

	// bin size: (error + total) / target, remainder carried
	bmd_divider #(
		.DW (ERR_BITS),
		.QW (COUNT_BITS),
		.VW (COUNT_BITS)
	) u_size_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.size_start),
		.dividend  (err_sum),
		.divisor   (target_q),
		.busy      (size_busy),
		.quotient  (size_quot),
		.remainder (size_rem)
	);

	// sign-magnitude means, truncated toward zero
	assign abs_x = sum_x_q[SUM_BITS-1] ? $unsigned(-sum_x_q) : $unsigned(sum_x_q);
	assign abs_y = sum_y_q[SUM_BITS-1] ? $unsigned(-sum_y_q) : $unsigned(sum_y_q);

	bmd_divider #(
		.DW (SUM_BITS),
		.QW (SAMPLE_BITS),
		.VW (COUNT_BITS)
	) u_mean_x_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mean_start),
		.dividend  (abs_x),
		.divisor   (fill_q),
		.busy      (busy_x),
		.quotient  (quot_x),
		.remainder (rem_x)
	);

	bmd_divider #(
		.DW (SUM_BITS),
		.QW (SAMPLE_BITS),
		.VW (COUNT_BITS)
	) u_mean_y_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mean_start),
		.dividend  (abs_y),
		.divisor   (fill_q),
		.busy      (busy_y),
		.quotient  (quot_y),
		.remainder (rem_y)
	);

	assign mean_x_val = sum_x_q[SUM_BITS-1] ? ('0 - quot_x) : quot_x;
	assign mean_y_val = sum_y_q[SUM_BITS-1] ? ('0 - quot_y) : quot_y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			target_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOTAL_SAMPLES: total_q <= cfg_data;
				REG_TARGET_BINS:   target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			err_q   <= '0;
			size_q  <= '0;
			fill_q  <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			last_q  <= 1'b0;
		end else if (run_clear) begin
			index_q <= '0;
			err_q   <= '0;
			size_q  <= '0;
			fill_q  <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else begin
			if (cmd.size_load) begin
				size_q <= size_quot;
				err_q  <= {1'b0, size_rem};
			end
			if (cmd.accum) begin
				sum_x_q <= sum_x_q + SUM_BITS'(x_q);
				sum_y_q <= sum_y_q + SUM_BITS'(y_q);
				fill_q  <= fill_inc;
				last_q  <= is_last;
				if (is_last) begin
					index_q <= '0;
					err_q   <= '0;
				end else begin
					index_q <= index_inc;
				end
			end
			if (cmd.emit_bin) begin
				fill_q  <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
			end
			if (cmd.emit_pass) begin
				index_q <= is_last ? '0 : index_inc;
			end
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			x_q <= x_sample;
			y_q <= y_sample;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_bin || cmd.emit_pass) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (cmd.emit_bin) begin
			mean_x_q     <= mean_x_val;
			mean_y_q     <= mean_y_val;
			count_q      <= fill_q;
			last_point_q <= last_q;
		end else if (cmd.emit_pass) begin
			mean_x_q     <= x_q;
			mean_y_q     <= y_q;
			count_q      <= COUNT_BITS'(1);
			last_point_q <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_x     = mean_x_q;
	assign mean_y     = mean_y_q;
	assign bin_count  = count_q;
	assign last_point = last_point_q;

	// checks
	`ASSERT_HOLDS(a_fill_within_size, clk, arst_n, 1'b1, fill_q <= size_q)
	`ASSERT_HOLDS(a_err_below_target, clk, arst_n, 1'b1,
		(err_q == '0) || (err_q < ERR_BITS'(target_q)))
	`ASSERT_HOLDS(a_emit_has_room, clk, arst_n, cmd.emit_bin || cmd.emit_pass, status.out_free)
	`ASSERT_HOLDS(a_mean_divisor_nonzero, clk, arst_n, cmd.mean_start,
		(fill_q != '0) && !size_busy)
	`ASSERT_HOLDS(a_mean_rem_below_fill, clk, arst_n, cmd.emit_bin,
		(rem_x < fill_q) && (rem_y < fill_q))
	`ASSERT_NEXT(a_emit_shows_beat, clk, arst_n, cmd.emit_bin || cmd.emit_pass, out_valid_q)

endmodule

// ----- rtl/core/bmd_ctrl.sv -----
module bmd_ctrl
	import bmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  bmd_status_t status,
	output bmd_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SIZE_WAIT,
		ST_ACCUM,
		ST_MEAN_START,
		ST_MEAN_WAIT,
		ST_EMIT_BIN,
		ST_EMIT_PASS
	} state_t;

	state_t state_q;
	state_t state_next;

	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					state_next      = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!status.compress) begin
					state_next = ST_EMIT_PASS;
				end else if (status.fill_zero) begin
					cmd.size_start = 1'b1;
					state_next     = ST_SIZE_WAIT;
				end else begin
					state_next = ST_ACCUM;
				end
			end
			ST_SIZE_WAIT: begin
				if (!status.size_busy) begin
					cmd.size_load = 1'b1;
					state_next    = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accum  = 1'b1;
				state_next = status.bin_end ? ST_MEAN_START : ST_IDLE;
			end
			ST_MEAN_START: begin
				cmd.mean_start = 1'b1;
				state_next     = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (!status.mean_busy) begin
					state_next = ST_EMIT_BIN;
				end
			end
			ST_EMIT_BIN: begin
				if (status.out_free) begin
					cmd.emit_bin = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			ST_EMIT_PASS: begin
				if (status.out_free) begin
					cmd.emit_pass = 1'b1;
					state_next    = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ----- rtl/core/bin_mean_decimator_unit.sv -----
// Bin mean decimator: averages a run of total_samples (x, y) points down to target_bins
// points, bins of floor or ceil of total_samples / target_bins, sized by an exact
// integer error carry. Each point carries the truncated means, the bin size and a
// flag on the last point of the run; with target_bins zero or not below total_samples
// every sample passes straight through. A write to either configuration register
// restarts the run. One item is handled at a time: a pass-through item is evaluated and
// emitted, an item inside a bin evaluated and accumulated, the first item of a bin also
// waits on the bit-serial size divider and the last on two bit-serial mean dividers in
// parallel. The output register lets the next item enter while a point waits.
module bin_mean_decimator_unit
	import bmd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [COUNT_BITS-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] x_sample,
	input  logic signed [SAMPLE_BITS-1:0] y_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] mean_x,
	output logic signed [SAMPLE_BITS-1:0] mean_y,
	output logic [COUNT_BITS-1:0]         bin_count,
	output logic                          last_point
);

	bmd_cmd_t    cmd;
	bmd_status_t status;

	// sequencer
	bmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// accumulators, dividers and output register
	bmd_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.x_sample   (x_sample),
		.y_sample   (y_sample),
		.cmd        (cmd),
		.status     (status),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.mean_x     (mean_x),
		.mean_y     (mean_y),
		.bin_count  (bin_count),
		.last_point (last_point)
	);

endmodule
